// ===== rtl/core/earm_pkg.sv =====
// ----------------------------------------------------------------------------
// earm_pkg
// Shared constants and helpers for the Euler-angle rotation matrix pipeline.
// ----------------------------------------------------------------------------
package earm_pkg;

  localparam int PHASE_BITS = 32;
  localparam int XY_BITS    = 36;
  localparam int ENTRY_BITS = 16;

  localparam logic signed [XY_BITS-1:0] CORDIC_INV_GAIN = 36'sd652032874;

  // atan(2^-i) in 2^-32 turn units.
  function automatic logic signed [PHASE_BITS:0] atan_turns(input int i);
    logic signed [PHASE_BITS:0] v;
    begin
      unique case (i)
        0: v = 33'sd536870912;  1: v = 33'sd316933406;
        2: v = 33'sd167458907;  3: v = 33'sd85004756;
        4: v = 33'sd42667331;   5: v = 33'sd21354465;
        6: v = 33'sd10680862;   7: v = 33'sd5340245;
        8: v = 33'sd2670163;    9: v = 33'sd1335087;
        10: v = 33'sd667544;    11: v = 33'sd333772;
        12: v = 33'sd166886;    13: v = 33'sd83443;
        14: v = 33'sd41721;     15: v = 33'sd20860;
        16: v = 33'sd10430;     17: v = 33'sd5215;
        18: v = 33'sd2607;      19: v = 33'sd1303;
        20: v = 33'sd651;       21: v = 33'sd325;
        22: v = 33'sd162;       23: v = 33'sd81;
        24: v = 33'sd40;        25: v = 33'sd20;
        26: v = 33'sd10;        27: v = 33'sd5;
        28: v = 33'sd2;         29: v = 33'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/core/euler_angle_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_angle_rotation_matrix
// z-x-z Euler angles to a Q1.n rotation matrix, fully pipelined.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata fields (lowest bit up)
// s_axis    in   angle_phi, angle_theta, angle_psi  (48 bits)
// m_axis    out  r00 r01 r02 r10 r11 r12 r20 r21 r22 (144 bits)
//
// One beat per cycle in, one per cycle out while the output is not stalled. The
// pipeline has one fold stage, one stage per CORDIC iteration, one rounding
// stage, then two product stages, a sum stage and the output register.
// rst clears only the valid bits. When m_axis_tready is low with a valid
// output beat the whole pipeline holds; s_axis_tready follows m_axis_tready or an empty output.
// ----------------------------------------------------------------------------
module euler_angle_rotation_matrix #(
  parameter int ANGLE_BITS     = 16,
  parameter int COEF_FRAC_BITS = 14,
  parameter int CORDIC_STAGES  = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // angle_phi [15:0], angle_theta [31:16], angle_psi [47:32]
  input  logic [47:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22, 16 bits each from bit 0
  output logic [143:0] m_axis_tdata
);

  localparam int PB  = earm_pkg::PHASE_BITS;
  localparam int XB  = earm_pkg::XY_BITS;
  localparam int EB  = earm_pkg::ENTRY_BITS;
  localparam int RS  = 30 - COEF_FRAC_BITS;
  localparam int NS  = CORDIC_STAGES;
  localparam int LAT = NS + 6;
  // Matrix terms stay within +-2^COEF_FRAC_BITS, so products need only this width.
  localparam int QB  = COEF_FRAC_BITS + 2;
  localparam logic signed [XB-1:0] ONE = XB'(1) <<< COEF_FRAC_BITS;
  localparam logic signed [XB-1:0] RHALF = (XB'(1) <<< RS) >>> 1;
  localparam logic signed [XB-1:0] PHALF = XB'(1) <<< (COEF_FRAC_BITS - 1);

  logic adv;
  logic [LAT-1:0] vld;

  assign adv = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  function automatic logic signed [XB-1:0] sat(input logic signed [XB-1:0] v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic logic signed [XB-1:0] mulq(input logic signed [XB-1:0] a,
                                                input logic signed [XB-1:0] b);
    logic signed [2*QB-1:0] p;
    begin
      p = QB'(a) * QB'(b) + (2*QB)'(PHALF);
      return XB'(p >>> COEF_FRAC_BITS);
    end
  endfunction

  // Three CORDIC lanes: phi, theta, psi.
  logic signed [PB:0]   z [3][NS+1];
  logic signed [XB-1:0] x [3][NS+1];
  logic signed [XB-1:0] y [3][NS+1];
  logic [NS:0]          flip [3];
  logic signed [XB-1:0] sn [3];
  logic signed [XB-1:0] cs [3];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [ANGLE_BITS-1:0] ang;
    logic [PB-1:0] ph;
    logic          fl;
    assign ang = ANGLE_BITS'(s_axis_tdata[16*l +: 16]);
    assign ph  = PB'(ang) << (PB - ANGLE_BITS);
    assign fl  = ph[PB-1] ^ ph[PB-2];

    always_ff @(posedge clk) begin
      if (adv) begin
        z[l][0]    <= (PB+1)'($signed(fl ? ph + {1'b1, {(PB-1){1'b0}}} : ph));
        x[l][0]    <= earm_pkg::CORDIC_INV_GAIN;
        y[l][0]    <= '0;
        flip[l][0] <= fl;
      end
    end

    for (genvar i = 0; i < NS; i++) begin : g_it
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!z[l][i][PB]) begin
            x[l][i+1] <= x[l][i] - (y[l][i] >>> i);
            y[l][i+1] <= y[l][i] + (x[l][i] >>> i);
            z[l][i+1] <= z[l][i] - earm_pkg::atan_turns(i);
          end else begin
            x[l][i+1] <= x[l][i] + (y[l][i] >>> i);
            y[l][i+1] <= y[l][i] - (x[l][i] >>> i);
            z[l][i+1] <= z[l][i] + earm_pkg::atan_turns(i);
          end
          flip[l][i+1] <= flip[l][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cs[l] <= sat(((flip[l][NS] ? -x[l][NS] : x[l][NS]) + RHALF) >>> RS);
        sn[l] <= sat(((flip[l][NS] ? -y[l][NS] : y[l][NS]) + RHALF) >>> RS);
      end
    end
  end

  // Lane 0 is phi, 1 theta, 2 psi.
  logic signed [XB-1:0] sph1, cph1, sth1, cth1, sps1, cps1, tsp, tcp;
  logic signed [XB-1:0] p [12];
  logic signed [XB-1:0] r [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      tsp  <= mulq(cs[1], sn[0]);
      tcp  <= mulq(cs[1], cs[0]);
      sph1 <= sn[0]; cph1 <= cs[0];
      sth1 <= sn[1]; cth1 <= cs[1];
      sps1 <= sn[2]; cps1 <= cs[2];

      p[0]  <= mulq(cps1, cph1);
      p[1]  <= mulq(tsp, sps1);
      p[2]  <= mulq(cps1, sph1);
      p[3]  <= mulq(tcp, sps1);
      p[4]  <= mulq(sps1, sth1);
      p[5]  <= mulq(sps1, cph1);
      p[6]  <= mulq(tsp, cps1);
      p[7]  <= mulq(sps1, sph1);
      p[8]  <= mulq(tcp, cps1);
      p[9]  <= mulq(cps1, sth1);
      p[10] <= mulq(sth1, sph1);
      p[11] <= mulq(sth1, cph1);
      r[8]  <= cth1;

      r[0] <= p[0] - p[1];
      r[1] <= p[2] + p[3];
      r[2] <= p[4];
      r[3] <= -p[5] - p[6];
      r[4] <= -p[7] + p[8];
      r[5] <= p[9];
      r[6] <= p[10];
      r[7] <= -p[11];
    end
  end

  // The r[8] register is one stage early; delay it to line up with the sums.
  logic signed [XB-1:0] r8d;
  always_ff @(posedge clk) begin
    if (adv) begin
      r8d <= r[8];
      for (int k = 0; k < 8; k++) begin
        m_axis_tdata[EB*k +: EB] <= EB'(sat(r[k]));
      end
      m_axis_tdata[EB*8 +: EB] <= EB'(sat(r8d));
    end
  end

  ap_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");
  ap_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  ap_flow: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule
